[hw/rtl/psab_pkg.sv]
`timescale 1ns / 1ps
package psab_pkg;

    // Coordinate width: pixel index plus window offset, signed
    localparam int CW      = 14;
    // Magnitude of a window offset
    localparam int MAG_W   = 6;
    // Squared distance dx*dx+dy*dy
    localparam int D2_W    = 12;
    // Shared subtract/compare unit width
    localparam int ALU_W   = 28;
    // Integer square root result, distance in 1/256 pixel
    localparam int ROOT_W  = 14;
    // Product alpha*fade and full opacity product
    localparam int AF_W    = 18;
    localparam int P_W     = 27;
    // Blend counter
    localparam int CNT_W   = 11;

    localparam logic [CNT_W-1:0] CNT_MAX    = 11'd2047;
    // Smallest opacity product above the 0.005 threshold
    localparam logic [P_W-1:0]   BLEND_MIN  = 27'd83887;
    // Ring ramp: (RING_BASE - 8*e) / 15 via reciprocal multiply
    localparam logic [11:0]      RING_BASE  = 12'd3072;
    localparam logic [12:0]      RING_RECIP = 13'd4370;
    localparam logic [ALU_W-1:0] SQRT_BIT0  = 28'h4000000;

    // Item kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_DRAW  = 2'd2;

    // Register indexes
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ACCESS,
        ST_READ_WAIT,
        ST_PIXEL,
        ST_SQRT,
        ST_CLASS,
        ST_DIV,
        ST_RING,
        ST_SCALE,
        ST_CHECK,
        ST_BLEND,
        ST_NEXT,
        ST_DONE
    } psab_state_t;

    // Result of the shared subtract/compare unit
    typedef struct packed {
        logic             ge;
        logic [ALU_W-1:0] diff;
    } alu_res_t;

endpackage

[hw/rtl/psab_sub_unit.sv]
`timescale 1ns / 1ps
module psab_sub_unit
    import psab_pkg::*;
(
    input  logic [ALU_W-1:0] op_a,
    input  logic [ALU_W-1:0] op_b,
    output alu_res_t         res
);

    // One compare and subtract, shared by square root and divider steps
    always_comb begin
        res.ge   = (op_a >= op_b);
        res.diff = op_a - op_b;
    end

endmodule

[hw/rtl/psab_frame_mem.sv]
`timescale 1ns / 1ps
module psab_frame_mem
    import psab_pkg::*;
#(
    parameter int DEPTH = 65536,
    parameter int AW    = 16
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [23:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [23:0]   rd_data
);

    logic [23:0] mem [DEPTH];

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[hw/rtl/particle_splat_additive_blend.sv]
`timescale 1ns / 1ps
// Particle splat into an RGB frame store with saturating additive blend.
// Pixel write (kind 0) and read (kind 1) access one pixel. A draw (kind 2)
// walks the clipped square window of radius min((size+24)>>4, MAX_RADIUS)
// one pixel at a time: a pixel outside the frame is skipped, a pixel inside
// takes the 14-step square root, a core pixel also the 8-step divider, both
// sharing one subtract/compare unit, and a blended pixel a read-modify-write
// of the frame store. A full window is 33 by 33 pixels. The input is not
// ready while an item is in work; a finished result waits in an output
// register while the next item is taken. The frame store is not cleared:
// read only pixels that were written.
module particle_splat_additive_blend
    import psab_pkg::*;
#(
    parameter int MAX_WIDTH  = 256,
    parameter int MAX_HEIGHT = 256,
    parameter int MAX_RADIUS = 16
) (
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [1:0]        s_kind,
    input  logic signed [15:0] s_pos_x,
    input  logic signed [15:0] s_pos_y,
    input  logic [7:0]        s_red,
    input  logic [7:0]        s_green,
    input  logic [7:0]        s_blue,
    input  logic [7:0]        s_spark_size,
    input  logic [8:0]        s_alpha,
    input  logic [8:0]        s_fade,
    // Result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_red,
    output logic [7:0]        m_out_green,
    output logic [7:0]        m_out_blue,
    output logic              m_status,
    output logic [CNT_W-1:0]  m_pixels_blended,
    // Configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    psab_state_t state_reg, state_next;

    logic [8:0]  fw_reg, fh_reg;
    logic [1:0]  kind_reg, kind_next;
    logic signed [CW-1:0] cx_reg, cx_next, cy_reg, cy_next;
    logic signed [CW-1:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [CW-1:0] rad_reg, rad_next;
    logic [7:0]  r_reg, r_next, g_reg, g_next, b_reg, b_next;
    logic [7:0]  s_reg, s_next;
    logic [AF_W-1:0] af_reg, af_next;
    logic [15:0] ss_reg, ss_next;
    logic [16:0] ss24_reg, ss24_next;
    logic [D2_W-1:0] d2_reg, d2_next;
    logic [ALU_W-1:0] sq_val_reg, sq_val_next, sq_root_reg, sq_root_next;
    logic [ALU_W-1:0] sq_bit_reg, sq_bit_next;
    logic [18:0] rem_reg, rem_next;
    logic [17:0] dsh_reg, dsh_next;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  dcnt_reg, dcnt_next;
    logic [8:0]  a_reg, a_next;
    logic [P_W-1:0] p_reg, p_next;
    logic [8:0]  pa_reg, pa_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [7:0]  res_r_reg, res_r_next, res_g_reg, res_g_next, res_b_reg, res_b_next;
    logic        res_st_reg, res_st_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_red_reg, m_green_reg, m_blue_reg;
    logic        m_status_reg;
    logic [CNT_W-1:0] m_cnt_reg;
    logic        out_load;

    // Address, clipping and helpers
    logic signed [CW-1:0] px_w, py_w, act_w, act_h;
    logic        inside_w;
    logic [AW-1:0] addr_w;
    logic [MAG_W-1:0] mx_w, my_w;
    logic signed [CW-1:0] ax_w, ay_w;
    logic [D2_W-1:0] sqx_w, sqy_w;
    logic signed [16:0] adj_x_w, adj_y_w;
    logic [4:0]  rad_raw_w;
    logic signed [CW-1:0] rad_w;
    logic [ALU_W-1:0] alu_a, alu_b;
    alu_res_t    alu_res;
    logic        wr_en, rd_en;
    logic [23:0] wr_data, rd_data;
    logic [ROOT_W-1:0] e_w;
    logic [11:0] num_w;
    logic [24:0] ring_prod_w;
    logic        cfg_wr;

    function automatic logic [7:0] add_sat(input logic [7:0] c, input logic [8:0] pa,
                                           input logic [7:0] col);
        logic [16:0] prod;
        logic [9:0]  sum;
        prod = {8'b0, pa} * {9'b0, col};
        sum  = {2'b0, c} + {1'b0, prod[16:8]};
        return (sum > 10'd255) ? 8'hFF : sum[7:0];
    endfunction

    // Configuration registers
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fw_reg <= 9'd256;
            fh_reg <= 9'd256;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_FRAME_WIDTH:  fw_reg <= pwdata[8:0];
                REG_FRAME_HEIGHT: fh_reg <= pwdata[8:0];
                default: ;
            endcase
        end
    end
    assign prdata = {23'b0, (paddr[2] == REG_FRAME_HEIGHT) ? fh_reg : fw_reg};

    // Active frame size, saturated at the store size
    assign act_w = ({{(CW-9){1'b0}}, fw_reg} > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                 : {{(CW-9){1'b0}}, fw_reg};
    assign act_h = ({{(CW-9){1'b0}}, fh_reg} > CW'(MAX_HEIGHT)) ? CW'(MAX_HEIGHT)
                 : {{(CW-9){1'b0}}, fh_reg};

    // Current pixel position and its store address
    assign px_w = cx_reg + dx_reg;
    assign py_w = cy_reg + dy_reg;
    assign inside_w = !px_w[CW-1] && (px_w < act_w) && !py_w[CW-1] && (py_w < act_h);
    assign addr_w = AW'(py_w[CW-2:0]) * AW'(MAX_WIDTH) + AW'(px_w[CW-2:0]);

    // Squared distance of the window offset
    assign ax_w = dx_reg[CW-1] ? -dx_reg : dx_reg;
    assign ay_w = dy_reg[CW-1] ? -dy_reg : dy_reg;
    assign mx_w = ax_w[MAG_W-1:0];
    assign my_w = ay_w[MAG_W-1:0];
    assign sqx_w = {{(D2_W-MAG_W){1'b0}}, mx_w} * {{(D2_W-MAG_W){1'b0}}, mx_w};
    assign sqy_w = {{(D2_W-MAG_W){1'b0}}, my_w} * {{(D2_W-MAG_W){1'b0}}, my_w};

    // Center: position / 16 truncated toward zero
    assign adj_x_w = {s_pos_x[15], s_pos_x} + (s_pos_x[15] ? 17'sd15 : 17'sd0);
    assign adj_y_w = {s_pos_y[15], s_pos_y} + (s_pos_y[15] ? 17'sd15 : 17'sd0);

    // Window radius
    assign rad_raw_w = 5'(({1'b0, s_spark_size} + 9'd24) >> 4);
    assign rad_w = ({{(CW-5){1'b0}}, rad_raw_w} > CW'(MAX_RADIUS)) ? CW'(MAX_RADIUS)
                 : {{(CW-5){1'b0}}, rad_raw_w};

    // Ring ramp
    assign e_w = sq_root_reg[ROOT_W-1:0] - {2'b0, s_reg, 4'b0};
    assign num_w = RING_BASE - {e_w[8:0], 3'b0};
    assign ring_prod_w = {13'b0, num_w} * {12'b0, RING_RECIP};

    // Shared unit operands
    always_comb begin
        if (state_reg == ST_DIV) begin
            alu_a = {{(ALU_W-19){1'b0}}, rem_reg};
            alu_b = {{(ALU_W-18){1'b0}}, dsh_reg};
        end else begin
            alu_a = sq_val_reg;
            alu_b = sq_root_reg + sq_bit_reg;
        end
    end

    psab_sub_unit u_sub (
        .op_a (alu_a),
        .op_b (alu_b),
        .res  (alu_res)
    );

    psab_frame_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (addr_w),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (addr_w),
        .rd_data (rd_data)
    );

    assign s_ready  = (state_reg == ST_IDLE);
    assign out_load = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        kind_next    = kind_reg;
        cx_next      = cx_reg;
        cy_next      = cy_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        rad_next     = rad_reg;
        r_next       = r_reg;
        g_next       = g_reg;
        b_next       = b_reg;
        s_next       = s_reg;
        af_next      = af_reg;
        ss_next      = ss_reg;
        ss24_next    = ss24_reg;
        d2_next      = d2_reg;
        sq_val_next  = sq_val_reg;
        sq_root_next = sq_root_reg;
        sq_bit_next  = sq_bit_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        quo_next     = quo_reg;
        dcnt_next    = dcnt_reg;
        a_next       = a_reg;
        p_next       = p_reg;
        pa_next      = pa_reg;
        cnt_next     = cnt_reg;
        res_r_next   = res_r_reg;
        res_g_next   = res_g_reg;
        res_b_next   = res_b_reg;
        res_st_next  = res_st_reg;
        wr_en        = 1'b0;
        rd_en        = 1'b0;
        wr_data      = {r_reg, g_reg, b_reg};

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    cx_next     = {adj_x_w[16], adj_x_w[16:4]};
                    cy_next     = {adj_y_w[16], adj_y_w[16:4]};
                    r_next      = s_red;
                    g_next      = s_green;
                    b_next      = s_blue;
                    s_next      = s_spark_size;
                    af_next     = {9'b0, s_alpha} * {9'b0, s_fade};
                    ss_next     = {8'b0, s_spark_size} * {8'b0, s_spark_size};
                    ss24_next   = ({9'b0, s_spark_size} + 17'd24)
                                * ({9'b0, s_spark_size} + 17'd24);
                    rad_next    = rad_w;
                    cnt_next    = '0;
                    res_r_next  = '0;
                    res_g_next  = '0;
                    res_b_next  = '0;
                    res_st_next = 1'b0;
                    if (s_kind == KIND_DRAW) begin
                        dx_next    = -rad_w;
                        dy_next    = -rad_w;
                        state_next = ST_PIXEL;
                    end else begin
                        dx_next    = '0;
                        dy_next    = '0;
                        state_next = (s_kind == KIND_WRITE || s_kind == KIND_READ)
                                   ? ST_ACCESS : ST_DONE;
                    end
                end
            end
            // Single pixel write or read
            ST_ACCESS: begin
                if (!inside_w) begin
                    res_st_next = 1'b1;
                    state_next  = ST_DONE;
                end else if (kind_reg == KIND_WRITE) begin
                    wr_en      = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    rd_en      = 1'b1;
                    state_next = ST_READ_WAIT;
                end
            end
            ST_READ_WAIT: begin
                res_r_next = rd_data[23:16];
                res_g_next = rd_data[15:8];
                res_b_next = rd_data[7:0];
                state_next = ST_DONE;
            end
            // Clip, then start the square root of d2 * 65536
            ST_PIXEL: begin
                if (!inside_w) begin
                    state_next = ST_NEXT;
                end else begin
                    d2_next      = sqx_w + sqy_w;
                    sq_val_next  = {sqx_w + sqy_w, 16'b0};
                    sq_root_next = '0;
                    sq_bit_next  = SQRT_BIT0;
                    state_next   = ST_SQRT;
                end
            end
            ST_SQRT: begin
                if (alu_res.ge) begin
                    sq_val_next  = alu_res.diff;
                    sq_root_next = (sq_root_reg >> 1) + sq_bit_reg;
                end else begin
                    sq_root_next = sq_root_reg >> 1;
                end
                sq_bit_next = sq_bit_reg >> 2;
                if (sq_bit_reg[0]) begin
                    state_next = ST_CLASS;
                end
            end
            // Core, ring or outside
            ST_CLASS: begin
                if ({d2_reg, 8'b0} < {4'b0, ss_reg}) begin
                    rem_next   = 19'(sq_root_reg[ROOT_W-1:0]) * 19'd24;
                    dsh_next   = {11'({3'b0, s_reg} * 11'd5), 7'b0};
                    quo_next   = '0;
                    dcnt_next  = 3'd7;
                    state_next = ST_DIV;
                end else if ({d2_reg, 8'b0} < {3'b0, ss24_reg}) begin
                    state_next = ST_RING;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_DIV: begin
                if (alu_res.ge) begin
                    rem_next = alu_res.diff[18:0];
                end
                quo_next  = {quo_reg[6:0], alu_res.ge};
                dsh_next  = dsh_reg >> 1;
                dcnt_next = dcnt_reg - 3'd1;
                if (dcnt_reg == 3'd0) begin
                    a_next     = 9'd256 - {1'b0, quo_reg[6:0], alu_res.ge};
                    state_next = ST_SCALE;
                end
            end
            ST_RING: begin
                a_next     = ring_prod_w[24:16];
                state_next = ST_SCALE;
            end
            ST_SCALE: begin
                p_next     = {{(AF_W){1'b0}}, a_reg} * {{(P_W-AF_W){1'b0}}, af_reg};
                state_next = ST_CHECK;
            end
            // Threshold and fetch the pixel
            ST_CHECK: begin
                if (p_reg >= BLEND_MIN) begin
                    pa_next    = (p_reg[26:16] > 11'd256) ? 9'd256 : p_reg[24:16];
                    rd_en      = 1'b1;
                    state_next = ST_BLEND;
                end else begin
                    state_next = ST_NEXT;
                end
            end
            ST_BLEND: begin
                wr_en   = 1'b1;
                wr_data = {add_sat(rd_data[23:16], pa_reg, r_reg),
                           add_sat(rd_data[15:8], pa_reg, g_reg),
                           add_sat(rd_data[7:0], pa_reg, b_reg)};
                if (cnt_reg != CNT_MAX) begin
                    cnt_next = cnt_reg + 1'b1;
                end
                state_next = ST_NEXT;
            end
            // Window walk
            ST_NEXT: begin
                if (dx_reg == rad_reg) begin
                    dx_next = -rad_reg;
                    if (dy_reg == rad_reg) begin
                        state_next = ST_DONE;
                    end else begin
                        dy_next    = dy_reg + 1'b1;
                        state_next = ST_PIXEL;
                    end
                end else begin
                    dx_next    = dx_reg + 1'b1;
                    state_next = ST_PIXEL;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output register handshake
    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        kind_reg    <= kind_next;
        cx_reg      <= cx_next;
        cy_reg      <= cy_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        rad_reg     <= rad_next;
        r_reg       <= r_next;
        g_reg       <= g_next;
        b_reg       <= b_next;
        s_reg       <= s_next;
        af_reg      <= af_next;
        ss_reg      <= ss_next;
        ss24_reg    <= ss24_next;
        d2_reg      <= d2_next;
        sq_val_reg  <= sq_val_next;
        sq_root_reg <= sq_root_next;
        sq_bit_reg  <= sq_bit_next;
        rem_reg     <= rem_next;
        dsh_reg     <= dsh_next;
        quo_reg     <= quo_next;
        dcnt_reg    <= dcnt_next;
        a_reg       <= a_next;
        p_reg       <= p_next;
        pa_reg      <= pa_next;
        cnt_reg     <= cnt_next;
        res_r_reg   <= res_r_next;
        res_g_reg   <= res_g_next;
        res_b_reg   <= res_b_next;
        res_st_reg  <= res_st_next;
        if (out_load) begin
            m_red_reg    <= res_r_reg;
            m_green_reg  <= res_g_reg;
            m_blue_reg   <= res_b_reg;
            m_status_reg <= res_st_reg;
            m_cnt_reg    <= cnt_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_out_red        = m_red_reg;
    assign m_out_green      = m_green_reg;
    assign m_out_blue       = m_blue_reg;
    assign m_status         = m_status_reg;
    assign m_pixels_blended = m_cnt_reg;

    // Checks
    a_wr_state: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_en |-> (state_reg == ST_ACCESS || state_reg == ST_BLEND))
        else $error("frame write outside access or blend");

    a_sqrt_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SQRT) |-> $onehot(sq_bit_reg))
        else $error("square root step bit not one-hot");

    a_valid_rise: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside done state");

    a_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_PIXEL) |-> (rad_reg <= CW'(MAX_RADIUS) && dx_reg <= rad_reg
                                     && dy_reg <= rad_reg && dx_reg >= -rad_reg))
        else $error("window offset out of range");

endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps
module tb_top;
    import psab_pkg::*;

    localparam int FW_MAX = 256;
    localparam int FH_MAX = 256;
    localparam int RAD_MAX = 16;
    localparam logic [2:0] ADDR_WIDTH = 3'd0;
    localparam logic [2:0] ADDR_HEIGHT = 3'd4;
    localparam logic [1:0] KIND_NONE = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] pos_x;
        logic [15:0] pos_y;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  spark_size;
        logic [8:0]  alpha;
        logic [8:0]  fade;
    } splat_req_t;

    typedef struct packed {
        logic [7:0]       out_red;
        logic [7:0]       out_green;
        logic [7:0]       out_blue;
        logic             status;
        logic [CNT_W-1:0] pixels_blended;
    } splat_rsp_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [1:0] s_kind = '0;
    logic signed [15:0] s_pos_x = '0;
    logic signed [15:0] s_pos_y = '0;
    logic [7:0] s_red = '0, s_green = '0, s_blue = '0, s_spark_size = '0;
    logic [8:0] s_alpha = '0, s_fade = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [7:0] m_out_red, m_out_green, m_out_blue;
    logic m_status;
    logic [CNT_W-1:0] m_pixels_blended;
    logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    particle_splat_additive_blend u_dut (.*);

    always #4 aclk = ~aclk;

    // Shadow frame and register copies
    logic [23:0] shadow_frame [FW_MAX*FH_MAX];
    bit          written [FW_MAX*FH_MAX];
    int unsigned frame_w_reg = 256, frame_h_reg = 256;

    splat_req_t pending_reqs[$];
    splat_rsp_t expected_rsps[$];
    int errors = 0;
    int hold_off = 0;    // long receiver stall, cycles
    bit pause_sender = 0;

    function automatic int unsigned act_w();
        return frame_w_reg > FW_MAX ? FW_MAX : frame_w_reg;
    endfunction
    function automatic int unsigned act_h();
        return frame_h_reg > FH_MAX ? FH_MAX : frame_h_reg;
    endfunction

    function automatic int unsigned int_sqrt(int unsigned v);
        int unsigned root, bitv;
        root = 0;
        bitv = 32'h4000_0000;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= root + bitv) begin
                v -= root + bitv;
                root = (root >> 1) + bitv;
            end else begin
                root >>= 1;
            end
            bitv >>= 2;
        end
        return root;
    endfunction

    function automatic int unsigned sat_add(int unsigned c, int unsigned a, int unsigned col);
        int unsigned v;
        v = c + ((a * col) >> 8);
        return v > 255 ? 255 : v;
    endfunction

    // Splat the particle into the shadow frame, return blended pixel count
    function automatic int unsigned splat_particle(int cx, int cy, splat_req_t r);
        int rad, px, py, w, h;
        int unsigned s, d2, q, dd, a, pa, cnt, idx;
        longint unsigned p;
        logic [23:0] pix;
        s = r.spark_size;
        w = act_w();
        h = act_h();
        rad = (s + 24) >> 4;
        if (rad > RAD_MAX) rad = RAD_MAX;
        cnt = 0;
        for (int dy = -rad; dy <= rad; dy++) begin
            for (int dx = -rad; dx <= rad; dx++) begin
                px = cx + dx;
                py = cy + dy;
                if (px < 0 || px >= w || py < 0 || py >= h) continue;
                d2 = dx * dx + dy * dy;
                q = d2 * 256;
                dd = int_sqrt(d2 << 16);
                if (q < s * s) a = 256 - (24 * dd) / (5 * s);
                else if (q < (s + 24) * (s + 24)) a = (3072 - 8 * (dd - 16 * s)) / 15;
                else a = 0;
                p = longint'(a) * r.alpha * r.fade;
                if (p * 200 > 64'd16777216) begin
                    idx = py * FW_MAX + px;
                    pix = shadow_frame[idx];
                    pa = p >> 16;
                    if (pa > 256) pa = 256;
                    shadow_frame[idx] = {sat_add(pix[23:16], pa, r.red)[7:0],
                                         sat_add(pix[15:8], pa, r.green)[7:0],
                                         sat_add(pix[7:0], pa, r.blue)[7:0]};
                    written[idx] = 1;
                    cnt++;
                end
            end
        end
        return cnt > 2047 ? 2047 : cnt;
    endfunction

    function automatic splat_rsp_t predict_splat(splat_req_t r);
        splat_rsp_t rsp;
        int cx, cy, idx;
        rsp = '0;
        cx = $signed(r.pos_x) / 16;
        cy = $signed(r.pos_y) / 16;
        if (r.kind == KIND_WRITE || r.kind == KIND_READ) begin
            if (!(cx >= 0 && cx < act_w() && cy >= 0 && cy < act_h())) begin
                rsp.status = 1'b1;
            end else begin
                idx = cy * FW_MAX + cx;
                if (r.kind == KIND_WRITE) begin
                    shadow_frame[idx] = {r.red, r.green, r.blue};
                    written[idx] = 1;
                end else begin
                    {rsp.out_red, rsp.out_green, rsp.out_blue} = shadow_frame[idx];
                end
            end
        end else if (r.kind == KIND_DRAW) begin
            rsp.pixels_blended = splat_particle(cx, cy, r)[CNT_W-1:0];
        end
        return rsp;
    endfunction

    // Driver: one transfer at a time with random gaps
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !s_ready) begin
            // hold
        end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            s_valid <= 1'b0;
        end else if (pending_reqs.size() > 0 && !pause_sender) begin
            splat_req_t r;
            r = pending_reqs.pop_front();
            expected_rsps.push_back(predict_splat(r));
            s_valid <= 1'b1;
            s_kind <= r.kind; s_pos_x <= r.pos_x; s_pos_y <= r.pos_y;
            s_red <= r.red; s_green <= r.green; s_blue <= r.blue;
            s_spark_size <= r.spark_size; s_alpha <= r.alpha; s_fade <= r.fade;
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Monitor: compare each result transfer with the oldest expectation
    int stall_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                splat_rsp_t got;
                splat_rsp_t exp_rsp;
                got = {m_out_red, m_out_green, m_out_blue, m_status, m_pixels_blended};
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected result %h", $realtime, got);
                    errors++;
                end else begin
                    exp_rsp = expected_rsps.pop_front();
                    if (got.out_red !== exp_rsp.out_red)
                        $display("%0t: out_red exp %0d got %0d", $realtime, exp_rsp.out_red, got.out_red);
                    if (got.out_green !== exp_rsp.out_green)
                        $display("%0t: out_green exp %0d got %0d", $realtime, exp_rsp.out_green, got.out_green);
                    if (got.out_blue !== exp_rsp.out_blue)
                        $display("%0t: out_blue exp %0d got %0d", $realtime, exp_rsp.out_blue, got.out_blue);
                    if (got.status !== exp_rsp.status)
                        $display("%0t: status exp %0d got %0d", $realtime, exp_rsp.status, got.status);
                    if (got.pixels_blended !== exp_rsp.pixels_blended)
                        $display("%0t: pixels_blended exp %0d got %0d", $realtime,
                                 exp_rsp.pixels_blended, got.pixels_blended);
                    if (got !== exp_rsp) errors++;
                end
            end
            if (hold_off > 0) begin
                hold_off <= hold_off - 1;
                m_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (m_valid && m_ready)
                    stall_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            end
        end
    end

    task automatic apb_write(input logic [2:0] addr, input int unsigned val);
        @(posedge aclk);
        psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (addr == ADDR_WIDTH) frame_w_reg = val & 9'h1FF;
        else frame_h_reg = val & 9'h1FF;
    endtask

    task automatic drain();
        wait (pending_reqs.size() == 0 && expected_rsps.size() == 0);
        repeat (20) @(posedge aclk);
    endtask

    // Pick a pixel position, in frame or not; plan_push turns reads of unwritten pixels into writes
    function automatic splat_req_t rand_req(int w, int h);
        splat_req_t r;
        int sel, px, py;
        r.red = $urandom; r.green = $urandom; r.blue = $urandom;
        r.alpha = $urandom_range(0, 256); r.fade = $urandom_range(0, 256);
        if ($urandom_range(0, 9) == 0) begin
            r.alpha = $urandom; r.fade = $urandom;
        end
        r.spark_size = ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, 48);
        px = $urandom_range(0, w + 1) - 1;
        py = $urandom_range(0, h + 1) - 1;
        r.pos_x = px * 16 + (px < 0 ? -$urandom_range(0, 15) : $urandom_range(0, 15));
        r.pos_y = py * 16 + (py < 0 ? -$urandom_range(0, 15) : $urandom_range(0, 15));
        if ($urandom_range(0, 15) == 0) begin
            r.pos_x = $urandom; r.pos_y = $urandom;
        end
        sel = $urandom_range(0, 9);
        if (sel < 3) r.kind = KIND_WRITE;
        else if (sel < 6) r.kind = KIND_READ;
        else if (sel < 9) r.kind = KIND_DRAW;
        else r.kind = KIND_NONE;
        return r;
    endfunction

    // Reads only go to pixels already written (after items queued ahead)
    bit plan_written [FW_MAX*FH_MAX];
    function automatic void plan_push(splat_req_t r);
        int cx, cy, rad;
        cx = $signed(r.pos_x) / 16;
        cy = $signed(r.pos_y) / 16;
        if (r.kind == KIND_READ && cx >= 0 && cx < act_w() && cy >= 0 && cy < act_h()
            && !plan_written[cy*FW_MAX+cx]) begin
            r.kind = KIND_WRITE;
        end
        if (r.kind == KIND_WRITE && cx >= 0 && cx < act_w() && cy >= 0 && cy < act_h())
            plan_written[cy*FW_MAX+cx] = 1;
        // a draw over unwritten pixels is avoided: precede with writes
        if (r.kind == KIND_DRAW) begin
            splat_req_t wr;
            rad = (r.spark_size + 24) >> 4;
            if (rad > RAD_MAX) rad = RAD_MAX;
            for (int y = cy - rad; y <= cy + rad; y++)
                for (int x = cx - rad; x <= cx + rad; x++)
                    if (x >= 0 && x < act_w() && y >= 0 && y < act_h()
                        && !plan_written[y*FW_MAX+x]) begin
                        wr = '0;
                        wr.kind = KIND_WRITE;
                        wr.pos_x = x * 16; wr.pos_y = y * 16;
                        wr.red = $urandom; wr.green = $urandom; wr.blue = $urandom;
                        plan_written[y*FW_MAX+x] = 1;
                        pending_reqs.push_back(wr);
                    end
        end
        pending_reqs.push_back(r);
    endfunction

    function automatic splat_req_t mk(logic [1:0] k, int x, int y, int s, int a, int f,
                                      int unsigned rgb);
        splat_req_t r;
        r.kind = k; r.pos_x = x; r.pos_y = y; r.spark_size = s;
        r.alpha = a; r.fade = f; {r.red, r.green, r.blue} = rgb[23:0];
        return r;
    endfunction

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Small frame keeps the window-fill writes short
        apb_write(ADDR_WIDTH, 40);
        apb_write(ADDR_HEIGHT, 30);
        plan_push(mk(KIND_WRITE, 0, 0, 0, 0, 0, 24'hFFFFFF));
        plan_push(mk(KIND_READ, 0, 0, 0, 0, 0, 0));
        plan_push(mk(KIND_WRITE, 39*16+15, 29*16+15, 0, 0, 0, 24'h000000));
        plan_push(mk(KIND_READ, 39*16+15, 29*16+15, 0, 0, 0, 0));
        plan_push(mk(KIND_WRITE, 40*16, 3*16, 0, 0, 0, 24'h123456));
        plan_push(mk(KIND_READ, 5*16, 30*16, 0, 0, 0, 0));
        plan_push(mk(KIND_READ, -1, 0, 0, 0, 0, 0));
        plan_push(mk(KIND_WRITE, -32768, 32767, 0, 0, 0, 24'hAAAAAA));
        plan_push(mk(KIND_WRITE, 32767, -32768, 0, 0, 0, 24'h555555));
        plan_push(mk(KIND_DRAW, 20*16+8, 15*16+8, 40, 256, 256, 24'h80FF10));
        plan_push(mk(KIND_DRAW, 0, 0, 0, 256, 256, 24'hFFFFFF));
        plan_push(mk(KIND_DRAW, 39*16, 29*16, 255, 511, 511, 24'hFFFFFF));
        plan_push(mk(KIND_DRAW, 10*16, 10*16, 1, 1, 1, 24'h010203));
        plan_push(mk(KIND_DRAW, -15, -15, 20, 300, 100, 24'h7F7F7F));
        plan_push(mk(KIND_NONE, 32767, 32767, 255, 511, 511, 24'hFFFFFF));
        plan_push(mk(KIND_READ, 20*16, 15*16, 0, 0, 0, 0));
        drain();

        // Receiver holds off while the sender keeps offering
        hold_off = 300;
        for (int i = 0; i < 40; i++) plan_push(rand_req(act_w(), act_h()));
        drain();

        // Phases over register settings, extremes included
        for (int ph = 0; ph < 6; ph++) begin
            int unsigned wv, hv;
            case (ph)
                0: begin wv = 1; hv = 1; end
                1: begin wv = 256; hv = 4; end
                2: begin wv = 3; hv = 256; end
                3: begin wv = 511; hv = 300; end
                4: begin wv = 0; hv = 0; end
                default: begin wv = $urandom_range(1, 64); hv = $urandom_range(1, 64); end
            endcase
            apb_write(ADDR_WIDTH, wv);
            apb_write(ADDR_HEIGHT, hv);
            for (int i = 0; i < 80; i++) begin
                splat_req_t r;
                r = rand_req(act_w() > 64 ? 64 : act_w(), act_h() > 64 ? 64 : act_h());
                if (ph >= 1 && ph <= 3 && i % 8 == 0 && r.kind == KIND_DRAW)
                    r.spark_size = 231;
                plan_push(r);
                if (i == 40) begin
                    pause_sender = 1;
                    wait (expected_rsps.size() == 0);
                    pause_sender = 0;
                end
            end
            drain();
        end

        if (errors == 0)
            $display("** particle_splat_additive_blend: PASSED **");
        else
            $display("** particle_splat_additive_blend: FAILED **");
        $finish;
    end

    initial begin
        #400ms;
        $display("** particle_splat_additive_blend: FAILED **");
        $finish;
    end
endmodule
